// ----- src/imufd_pkg.sv -----
package imufd_pkg;

  // Frame framing bytes
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC    = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  // Bytes held before the current one
  localparam int WIN_DEPTH = 10;
  localparam int FILL_W    = 4;

  // Scaling constants, signed Q12.16 outputs
  localparam logic signed [35:0] ACC_GAIN     = 36'sd80282;
  localparam logic signed [35:0] ACC_ROUND    = 36'sd128;
  localparam logic signed [35:0] GYRO_GAIN    = 36'sd4000;
  localparam logic signed [35:0] ANGLE_GAIN   = 36'sd360;
  localparam logic signed [35:0] ANGLE_OFFSET = 36'sd11796480;

  typedef enum logic [1:0] {
    KIND_ACC   = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2
  } frame_kind_t;

  typedef struct packed {
    frame_kind_t        kind;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } frame_hit_t;

  // Scale one raw axis sample into a 28-bit signed Q12.16 value
  function automatic logic signed [27:0] scale_axis(frame_kind_t kind,
                                                    logic signed [15:0] raw,
                                                    logic negate);
    logic signed [35:0] raw_ext;
    logic signed [35:0] gain;
    logic signed [35:0] prod;
    logic signed [35:0] val;
    raw_ext = $signed({{20{raw[15]}}, raw});
    case (kind)
      KIND_ACC:   gain = ACC_GAIN;
      KIND_GYRO:  gain = GYRO_GAIN;
      KIND_ANGLE: gain = ANGLE_GAIN;
      default:    gain = '0;
    endcase
    prod = raw_ext * gain;
    case (kind)
      // round half up, then floor by arithmetic shift
      KIND_ACC:   val = (prod + ACC_ROUND) >>> 8;
      KIND_GYRO:  val = prod;
      KIND_ANGLE: val = prod - ANGLE_OFFSET;
      default:    val = prod;
    endcase
    if (negate) begin
      val = -val;
    end
    return $signed(val[27:0]);
  endfunction

endpackage

// ----- src/imufd_if.sv -----
interface imufd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_start;

  modport source (output valid, output data_byte, output buffer_start, input ready);
  modport sink   (input valid, input data_byte, input buffer_start, output ready);
endinterface

interface imufd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic signed [27:0] value_x;
  logic signed [27:0] value_y;
  logic signed [27:0] value_z;

  modport source (output valid, output frame_kind, output value_x, output value_y,
                  output value_z, input ready);
  modport sink   (input valid, input frame_kind, input value_x, input value_y,
                  input value_z, output ready);
endinterface

// ----- src/imufd_window.sv -----
module imufd_window import imufd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       buffer_start,
  output logic       hit_valid,
  output frame_hit_t hit
);

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);
  localparam int PAIRS = WIN_DEPTH / 2;

  logic [7:0]        win_r [WIN_DEPTH];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [7:0]        pair_sum [PAIRS];
  logic [7:0]        win_sum;
  logic              full;
  logic              type_known;

  // Checksum as a shallow adder tree over the held bytes
  always_comb begin
    for (int k = 0; k < PAIRS; k++) begin
      pair_sum[k] = win_r[2*k] + win_r[2*k+1];
    end
    win_sum = (pair_sum[0] + pair_sum[1]) + (pair_sum[2] + pair_sum[3]) + pair_sum[4];
  end

  // Decode frame type and test for a complete frame
  always_comb begin
    full = (fill_r == FILL_FULL);
    type_known = 1'b1;
    hit.kind = KIND_ACC;
    case (win_r[1])
      TYPE_ACC:   hit.kind = KIND_ACC;
      TYPE_GYRO:  hit.kind = KIND_GYRO;
      TYPE_ANGLE: hit.kind = KIND_ANGLE;
      default:    type_known = 1'b0;
    endcase
    hit.raw_x = $signed({win_r[3], win_r[2]});
    hit.raw_y = $signed({win_r[5], win_r[4]});
    hit.raw_z = $signed({win_r[7], win_r[6]});
    hit_valid = accept && !buffer_start && full && (win_r[0] == HEADER_BYTE) &&
                (win_sum == data_byte) && type_known;
  end

  // Count held bytes; a new buffer restarts the count with this byte
  always_comb begin
    if (buffer_start) begin
      fill_nxt = FILL_W'(1);
    end else if (full) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  // Shift the new byte in; oldest drops off index 0
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < WIN_DEPTH - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[WIN_DEPTH-1] <= data_byte;
    end
  end

endmodule

// ----- src/imu_serial_frame_decoder_top.sv -----
// IMU serial frame decoder.
// in_chan carries one received serial byte per request, with buffer_start set
// on the first byte of a new buffer; the byte window is emptied before such a
// byte, so no frame spans two buffers. out_chan carries one request per valid
// frame of type acceleration, angular rate or angle: frame_kind and three
// signed Q12.16 axis values. Bytes that complete no frame give no request.
// Both channels complete a request when valid and ready are high at a rising
// clock edge.
// Throughput: one byte per cycle while in_chan.ready is high. Frames pass the
// frame test into the frame register, then scaling into the result register.
// The frame test is an adder tree over the held bytes; the scaling is one
// constant multiply per axis.
// Reset (rst_n low, synchronous) empties the window and drops any result in
// flight. When out_chan stalls, the result and one frame behind it are held;
// in_chan.ready falls only once both stages are occupied.
module imu_serial_frame_decoder_top import imufd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  imufd_in_if.sink   in_chan,
  imufd_out_if.source out_chan
);

  logic               accept;
  logic               hit_valid;
  frame_hit_t         hit;
  logic               s1_ready;
  logic               s2_ready;
  logic               s1_valid_r;
  logic               s1_valid_nxt;
  frame_hit_t         s1_hit_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  frame_kind_t        out_kind_r;
  logic signed [27:0] out_x_r;
  logic signed [27:0] out_y_r;
  logic signed [27:0] out_z_r;

  // Handshake: each stage moves when the one after it can take
  assign s2_ready       = !out_valid_r || out_chan.ready;
  assign s1_ready       = !s1_valid_r || s2_ready;
  assign in_chan.ready  = s1_ready;
  assign accept         = in_chan.valid && s1_ready;

  imufd_window u_window (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_chan.data_byte),
    .buffer_start (in_chan.buffer_start),
    .hit_valid    (hit_valid),
    .hit          (hit)
  );

  // Advance valid flags
  always_comb begin
    s1_valid_nxt  = s1_ready ? hit_valid : s1_valid_r;
    out_valid_nxt = s2_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the detected frame
  always_ff @(posedge clk) begin
    if (s1_ready && hit_valid) begin
      s1_hit_r <= hit;
    end
  end

  // Scale axes into the result register; negate gyro x and angle z
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      out_kind_r <= s1_hit_r.kind;
      out_x_r    <= scale_axis(s1_hit_r.kind, s1_hit_r.raw_x, s1_hit_r.kind == KIND_GYRO);
      out_y_r    <= scale_axis(s1_hit_r.kind, s1_hit_r.raw_y, 1'b0);
      out_z_r    <= scale_axis(s1_hit_r.kind, s1_hit_r.raw_z, s1_hit_r.kind == KIND_ANGLE);
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.frame_kind = out_kind_r;
  assign out_chan.value_x    = out_x_r;
  assign out_chan.value_y    = out_y_r;
  assign out_chan.value_z    = out_z_r;

endmodule

// ----- src/imufd_checker.sv -----
module imufd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_frame_kind,
  input logic signed [27:0] out_value_x,
  input logic signed [27:0] out_value_y,
  input logic signed [27:0] out_value_z
);

  // No result survives reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows a byte request through the frame and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without byte request two cycles earlier");

  // Input is never blocked while the result register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

  // Stalled result payload holds
  a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_frame_kind) && $stable(out_value_x) &&
                                $stable(out_value_y) && $stable(out_value_z))
    else $error("result payload changed under stall");

endmodule

bind imu_serial_frame_decoder_top imufd_checker u_imufd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_frame_kind (out_chan.frame_kind),
  .out_value_x    (out_chan.value_x),
  .out_value_y    (out_chan.value_y),
  .out_value_z    (out_chan.value_z)
);

// ----- tb/imu_serial_frame_decoder_top_tb.sv -----
module imu_serial_frame_decoder_top_tb;
  import imufd_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         drain_first;
  } serial_byte_t;

  typedef struct {
    frame_kind_t        kind;
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [27:0] z;
  } axis_triplet_t;

  logic clk;
  logic rst_n;

  imufd_in_if  in_chan();
  imufd_out_if out_chan();

  imu_serial_frame_decoder_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  serial_byte_t  byte_queue[$];
  axis_triplet_t expected_frames[$];

  // Byte history of the decoder as seen from the input side
  logic [7:0] held_bytes [WIN_DEPTH];
  int         held_count;

  int error_count = 0;
  int send_gap, send_calm;
  int recv_gap, recv_calm;

  // Clock and reset
  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.buffer_start = 1'b0;
    out_chan.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Scale one raw axis sample into signed Q12.16, truncated to the port width
  function automatic logic signed [27:0] axis_q16(frame_kind_t kind,
                                                  logic signed [15:0] raw,
                                                  bit negate);
    longint r;
    longint v;
    r = raw;
    case (kind)
      KIND_ACC:   v = (r * longint'(ACC_GAIN) + longint'(ACC_ROUND)) >>> 8;
      KIND_GYRO:  v = r * longint'(GYRO_GAIN);
      default:    v = r * longint'(ANGLE_GAIN) - longint'(ANGLE_OFFSET);
    endcase
    if (negate) v = -v;
    return v[27:0];
  endfunction

  // Test the held window against the new byte, then shift the byte in
  function automatic void decode_window_byte(logic [7:0] b, logic start);
    logic [7:0]         sum;
    logic signed [15:0] rx, ry, rz;
    axis_triplet_t      res;
    bit                 hit;
    hit = 1'b0;
    if (start) held_count = 0;
    if (held_count >= WIN_DEPTH && held_bytes[0] == HEADER_BYTE) begin
      sum = '0;
      for (int k = 0; k < WIN_DEPTH; k++) sum = sum + held_bytes[k];
      if (sum == b) begin
        rx = {held_bytes[3], held_bytes[2]};
        ry = {held_bytes[5], held_bytes[4]};
        rz = {held_bytes[7], held_bytes[6]};
        hit = 1'b1;
        case (held_bytes[1])
          TYPE_ACC:   res.kind = KIND_ACC;
          TYPE_GYRO:  res.kind = KIND_GYRO;
          TYPE_ANGLE: res.kind = KIND_ANGLE;
          default:    hit = 1'b0;
        endcase
        if (hit) begin
          res.x = axis_q16(res.kind, rx, res.kind == KIND_GYRO);
          res.y = axis_q16(res.kind, ry, 1'b0);
          res.z = axis_q16(res.kind, rz, res.kind == KIND_ANGLE);
          expected_frames.push_back(res);
        end
      end
    end
    if (held_count >= WIN_DEPTH) begin
      for (int k = 0; k + 1 < WIN_DEPTH; k++) held_bytes[k] = held_bytes[k + 1];
      held_bytes[WIN_DEPTH - 1] = b;
    end else begin
      held_bytes[held_count] = b;
      held_count++;
    end
  endfunction

  // Mostly short gaps, a few long ones, and now and then a run with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Queue a frame; start_pos marks the byte carrying buffer_start,
  // keep cuts the frame short
  function automatic void push_frame(logic [7:0] ftype, int rx, int ry, int rz,
                                     bit corrupt, int start_pos, int keep);
    logic [7:0]   bytes [11];
    logic [7:0]   sum;
    serial_byte_t sb;
    bytes[0] = HEADER_BYTE;
    bytes[1] = ftype;
    {bytes[3], bytes[2]} = rx[15:0];
    {bytes[5], bytes[4]} = ry[15:0];
    {bytes[7], bytes[6]} = rz[15:0];
    bytes[8] = 8'($urandom_range(0, 255));
    bytes[9] = 8'($urandom_range(0, 255));
    sum = '0;
    for (int k = 0; k < 10; k++) sum = sum + bytes[k];
    if (corrupt) sum = sum + 8'($urandom_range(1, 255));
    bytes[10] = sum;
    for (int k = 0; k < keep; k++) begin
      sb.data = bytes[k];
      sb.start = (k == start_pos);
      sb.drain_first = 1'b0;
      byte_queue.push_back(sb);
    end
  endfunction

  function automatic int pick_raw();
    case ($urandom_range(0, 9))
      0:       return -32768;
      1:       return 32767;
      2:       return 0;
      3:       return -1;
      default: return int'($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  function automatic void report_mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endfunction

  // Drive byte requests from the queue; predict each one as it is accepted
  always @(posedge clk) begin : drive_bytes
    serial_byte_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
      held_count = 0;
      foreach (held_bytes[k]) held_bytes[k] = '0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        decode_window_byte(in_chan.data_byte, in_chan.buffer_start);
      // hold a request until it is taken
      if (!in_chan.valid || in_chan.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (byte_queue.size() > 0 &&
                     !(byte_queue[0].drain_first && expected_frames.size() != 0)) begin
          nxt = byte_queue.pop_front();
          in_chan.valid <= 1'b1;
          in_chan.data_byte <= nxt.data;
          in_chan.buffer_start <= nxt.start;
          send_gap = pick_gap(send_calm);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Check each result request against the oldest expected frame
  always @(posedge clk) begin : check_frames
    axis_triplet_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_gap = 0;
      recv_calm = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result, kind %0d x %0d y %0d z %0d", $time,
                   out_chan.frame_kind, out_chan.value_x, out_chan.value_y,
                   out_chan.value_z);
          error_count++;
        end else begin
          want = expected_frames.pop_front();
          if (out_chan.frame_kind !== want.kind)
            report_mismatch("frame_kind", want.kind, out_chan.frame_kind);
          if (out_chan.value_x !== want.x)
            report_mismatch("value_x", want.x, out_chan.value_x);
          if (out_chan.value_y !== want.y)
            report_mismatch("value_y", want.y, out_chan.value_y);
          if (out_chan.value_z !== want.z)
            report_mismatch("value_z", want.z, out_chan.value_z);
        end
      end
      // stall the result side at random
      if (recv_gap > 0) begin
        recv_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        recv_gap = pick_gap(recv_calm);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int         first_random;
    logic [7:0] ftype;
    int         r, start_pos, keep;

    // one frame of each kind at the raw extremes, buffer_start on the first header
    push_frame(TYPE_ACC, 32767, -32768, 0, 1'b0, 0, 11);
    push_frame(TYPE_GYRO, -32768, 32767, -1, 1'b0, -1, 11);
    push_frame(TYPE_ANGLE, 32767, -32768, 1, 1'b0, -1, 11);
    // unknown type with a good checksum
    push_frame(8'h50, 100, -200, 300, 1'b0, -1, 11);
    // buffer_start on the checksum byte empties the window first
    push_frame(TYPE_ACC, -1, 1, 12345, 1'b0, 10, 11);

    first_random = byte_queue.size();
    while (byte_queue.size() < 550) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5:       ftype = TYPE_ACC;
          6, 7, 8, 9, 10, 11:     ftype = TYPE_GYRO;
          12, 13, 14, 15, 16, 17: ftype = TYPE_ANGLE;
          default:                ftype = 8'($urandom_range(0, 255));
        endcase
        start_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : -1;
        keep = ($urandom_range(0, 14) == 0) ? $urandom_range(1, 10) : 11;
        push_frame(ftype, pick_raw(), pick_raw(), pick_raw(),
                   $urandom_range(0, 9) == 0, start_pos, keep);
      end else begin
        // noise, with stray headers now and then
        repeat ($urandom_range(1, 8)) begin
          serial_byte_t sb;
          sb.data = ($urandom_range(0, 5) == 0) ? HEADER_BYTE : 8'($urandom_range(0, 255));
          sb.start = ($urandom_range(0, 15) == 0);
          sb.drain_first = 1'b0;
          byte_queue.push_back(sb);
        end
      end
    end
    // let the decoder drain before the random part and once midway
    byte_queue[first_random].drain_first = 1'b1;
    byte_queue[(first_random + byte_queue.size()) / 2].drain_first = 1'b1;

    @(posedge rst_n);
    while (byte_queue.size() != 0 || in_chan.valid) @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("imu_serial_frame_decoder_top_tb: clean");
    else
      $display("imu_serial_frame_decoder_top_tb: errors");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("imu_serial_frame_decoder_top_tb: errors");
    $finish;
  end

endmodule

// ----- files.f -----
src/imufd_pkg.sv
src/imufd_if.sv
src/imufd_window.sv
src/imu_serial_frame_decoder_top.sv
src/imufd_checker.sv
tb/imu_serial_frame_decoder_top_tb.sv
